// ===== design/assert_macros.svh =====
// Assertion macros shared by the relaxation engine RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, quiet during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle requires a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/sssp_pkg.sv =====
// Types and fixed constants for the single-source shortest-path relaxation engine.
// No dependencies; imported by the ALU and the top level.
package sssp_pkg;

   localparam int ID_W       = 10;
   localparam int DIST_W     = 30;
   localparam int WEIGHT_W   = 24;
   localparam int OP_W       = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [OP_W-1:0] OP_BEGIN    = 3'd0;
   localparam logic [OP_W-1:0] OP_IN_EDGE  = 3'd1;
   localparam logic [OP_W-1:0] OP_COMMIT   = 3'd2;
   localparam logic [OP_W-1:0] OP_OUT_EDGE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ     = 3'd4;
   localparam logic [OP_W-1:0] OP_INIT     = 3'd5;

   typedef struct packed {
      logic              has_result;
      logic [DIST_W-1:0] distance;
      logic              improved;
      logic              schedule;
      logic [ID_W-1:0]   target;
      logic [DIST_W-1:0] running_min;
      logic [ID_W-1:0]   current_vertex;
      logic              improved_flag;
      logic              store_wr;
      logic              start_init;
   } alu_out_type;

endpackage

// ===== design/sssp_relax_alu.sv =====
// Per-item datapath of the relaxation engine: saturating add, compare, minimum.
// Depends on sssp_pkg; combinational, used by sssp_vertex_relaxation.
module sssp_relax_alu import sssp_pkg::*; #(
   parameter int INFINITY_DIST = 1000000000
) (
   input  logic [OP_W-1:0]     op,
   input  logic [DIST_W-1:0]   loaded,
   input  logic [DIST_W-1:0]   running_min,
   input  logic                improved_flag,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [ID_W-1:0]     current_vertex,
   input  logic [ID_W-1:0]     node_id,
   input  logic [ID_W-1:0]     neighbor_id,
   input  logic [ID_W-1:0]     source_vertex,
   output alu_out_type         result
);

   localparam logic [DIST_W-1:0] INF = DIST_W'(INFINITY_DIST);

   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] add_a;
   logic [DIST_W-1:0] cand;

   // One adder serves both edge kinds: in-edge adds to the neighbor, out-edge to the minimum.
   assign add_a = (op == OP_OUT_EDGE) ? running_min : loaded;
   assign sum   = {1'b0, add_a} + (DIST_W + 1)'(weight);
   assign cand  = (sum >= {1'b0, INF}) ? INF : sum[DIST_W-1:0];

   always_comb begin
      result                = '0;
      result.running_min    = running_min;
      result.current_vertex = current_vertex;
      result.improved_flag  = improved_flag;
      case (op)
         OP_BEGIN: begin
            result.has_result     = 1'b1;
            result.current_vertex = node_id;
            result.running_min    = loaded;
            result.improved_flag  = 1'b0;
            result.distance       = loaded;
            result.target         = node_id;
         end
         OP_IN_EDGE: begin
            result.has_result  = 1'b1;
            result.running_min = (cand < running_min) ? cand : running_min;
            result.distance    = (cand < running_min) ? cand : running_min;
            result.target      = neighbor_id;
         end
         OP_COMMIT: begin
            result.has_result    = 1'b1;
            result.improved      = running_min < loaded;
            result.improved_flag = running_min < loaded;
            result.store_wr      = 1'b1;
            result.distance      = running_min;
            result.target        = current_vertex;
         end
         OP_OUT_EDGE: begin
            result.has_result = 1'b1;
            result.schedule   = improved_flag && (cand < loaded);
            result.distance   = cand;
            result.target     = neighbor_id;
         end
         OP_READ: begin
            result.has_result = 1'b1;
            result.distance   = loaded;
            result.target     = node_id;
         end
         OP_INIT: begin
            result.has_result     = 1'b1;
            result.start_init     = 1'b1;
            result.running_min    = INF;
            result.current_vertex = '0;
            result.improved_flag  = 1'b0;
            result.distance       = '0;
            result.target         = source_vertex;
         end
         default: begin
            // unused opcodes: no result, no state change
            result.has_result = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/sssp_vertex_relaxation.sv =====
// Each accepted item makes a single distance memory read, registered at the accepting
// edge; compare and write-back fill the following ST_EXEC state, which registers the
// result onto rsp_. req_tready is high only in ST_IDLE, so no new item is taken until
// the last has left ST_EXEC; an unaccepted result on rsp_ holds the next item.
// Reset (synchronous, active high) and the init opcode start a clearing pass over all
// VERTEX_COUNT entries that writes infinity (and zero at the source); req_tready stays
// low during the pass while csr_ writes are still taken.
`include "assert_macros.svh"

module sssp_vertex_relaxation import sssp_pkg::*; #(
   parameter int VERTEX_COUNT  = 1024,
   parameter int INFINITY_DIST = 1000000000
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration: source_vertex
   input  logic                  csr_wr_en,
   input  logic [ID_W-1:0]       csr_wr_data,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // node_id[9:0], neighbor_id[19:10],
                                             // edge_weight[43:20]
   input  logic [OP_W-1:0]       req_tuser,  // opcode[2:0]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // distance[29:0], improved[30],
                                             // schedule_neighbor[31], target_id[41:32]
);

   localparam int ADDR_W = $clog2(VERTEX_COUNT);
   localparam int EXT_W  = (ADDR_W > ID_W) ? ADDR_W : ID_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_COUNT - 1);
   localparam logic [DIST_W-1:0] INF       = DIST_W'(INFINITY_DIST);
   localparam int RSP_USED = DIST_W + 2 + ID_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   // Vertex ids beyond the store read as infinity and drop their writes.
   function automatic logic id_ok(input logic [ID_W-1:0] id);
      return int'(id) < VERTEX_COUNT;
   endfunction

   function automatic logic [ADDR_W-1:0] id_addr(input logic [ID_W-1:0] id);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(id);
      return ext[ADDR_W-1:0];
   endfunction

   // Unpack the request transfer.
   logic [OP_W-1:0]     req_op;
   logic [ID_W-1:0]     req_vid;
   logic [ID_W-1:0]     req_nid;
   logic [WEIGHT_W-1:0] req_weight;
   assign req_op     = req_tuser;
   assign req_vid    = req_tdata[ID_W-1:0];
   assign req_nid    = req_tdata[2*ID_W-1:ID_W];
   assign req_weight = req_tdata[2*ID_W+WEIGHT_W-1:2*ID_W];

   logic [1:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ID_W-1:0]     vid_ff, vid_in;
   logic [ID_W-1:0]     nid_ff, nid_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [DIST_W-1:0]   rdata_ff;
   logic [ID_W-1:0]     cur_ff, cur_in;
   logic [DIST_W-1:0]   rmin_ff, rmin_in;
   logic                impf_ff, impf_in;
   logic [ID_W-1:0]     src_ff, src_in;
   logic [ID_W-1:0]     sweep_src_ff, sweep_src_in;
   logic [ADDR_W-1:0]   sweep_idx_ff, sweep_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic [ID_W-1:0]   rd_id;
   logic              exec_go;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DIST_W-1:0] mem_wdata;
   logic [DIST_W-1:0] loaded;
   alu_out_type       alu;

   logic [DIST_W-1:0] dist_mem [VERTEX_COUNT];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Commit reads the vertex it will overwrite; edges read the neighbor.
   always_comb begin
      case (req_op)
         OP_COMMIT:   rd_id = cur_ff;
         OP_IN_EDGE,
         OP_OUT_EDGE: rd_id = req_nid;
         default:     rd_id = req_vid;
      endcase
   end

   assign loaded = rd_ok_ff ? rdata_ff : INF;

   sssp_relax_alu #(
      .INFINITY_DIST (INFINITY_DIST)
   ) u_alu (
      .op             (op_ff),
      .loaded         (loaded),
      .running_min    (rmin_ff),
      .improved_flag  (impf_ff),
      .weight         (weight_ff),
      .current_vertex (cur_ff),
      .node_id        (vid_ff),
      .neighbor_id    (nid_ff),
      .source_vertex  (src_ff),
      .result         (alu)
   );

   // Hold the item while its result cannot enter a full output register.
   assign exec_go = !alu.has_result || !rsp_valid_ff || rsp_tready;

   // Single write port: the clearing pass or a commit write-back.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_idx_ff;
      mem_wdata = INF;
      if (state_ff == ST_SWEEP) begin
         mem_we = 1'b1;
         if (id_ok(sweep_src_ff) && (sweep_idx_ff == id_addr(sweep_src_ff))) begin
            mem_wdata = '0;
         end
      end else if ((state_ff == ST_EXEC) && exec_go && alu.store_wr && id_ok(cur_ff)) begin
         mem_we    = 1'b1;
         mem_waddr = id_addr(cur_ff);
         mem_wdata = rmin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dist_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rdata_ff <= dist_mem[id_addr(rd_id)];
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      vid_in       = vid_ff;
      nid_in       = nid_ff;
      weight_in    = weight_ff;
      rd_ok_in     = rd_ok_ff;
      cur_in       = cur_ff;
      rmin_in      = rmin_ff;
      impf_in      = impf_ff;
      src_in       = csr_wr_en ? csr_wr_data : src_ff;
      sweep_src_in = sweep_src_ff;
      sweep_idx_in = sweep_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // capture the item; the memory read is under way
               op_in     = req_op;
               vid_in    = req_vid;
               nid_in    = req_nid;
               weight_in = req_weight;
               rd_ok_in  = id_ok(rd_id);
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               cur_in  = alu.current_vertex;
               rmin_in = alu.running_min;
               impf_in = alu.improved_flag;
               if (alu.has_result) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {(RSP_DATA_W - RSP_USED)'(0), alu.target, alu.schedule,
                                  alu.improved, alu.distance};
               end
               if (alu.start_init) begin
                  // latch the source so later csr writes do not disturb the pass
                  sweep_src_in = src_ff;
                  sweep_idx_in = '0;
                  state_in     = ST_SWEEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_idx_ff == LAST_ADDR) begin
               sweep_idx_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_idx_ff <= '0;
         sweep_src_ff <= '0;
         src_ff       <= '0;
         cur_ff       <= '0;
         rmin_ff      <= INF;
         impf_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
         sweep_src_ff <= sweep_src_in;
         src_ff       <= src_in;
         cur_ff       <= cur_in;
         rmin_ff      <= rmin_in;
         impf_ff      <= impf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      vid_ff      <= vid_in;
      nid_ff      <= nid_in;
      weight_ff   <= weight_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_CLK(a_sweep_blocks_input, clock, reset,
      (state_ff == ST_SWEEP) |-> !req_tready,
      "request taken during clearing pass")
   `ASSERT_CLK(a_commit_only_writes, clock, reset,
      mem_we && (state_ff != ST_SWEEP) |-> (op_ff == OP_COMMIT) && exec_go,
      "memory write outside commit")
   `ASSERT_NEXT(a_init_starts_sweep, clock, reset,
      (state_ff == ST_EXEC) && exec_go && (op_ff == OP_INIT),
      (state_ff == ST_SWEEP) && (sweep_idx_ff == '0),
      "init did not start clearing pass")
   `ASSERT_CLK(a_rsp_from_exec, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC),
      "response raised outside execute")

endmodule
